/* src/wavetable_voice_mixer_defines.svh */
// Assertion macros shared by the wavetable voice mixer modules.
`ifndef WAVETABLE_VOICE_MIXER_DEFINES_SVH
`define WAVETABLE_VOICE_MIXER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WVM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wvm assertion failed");

// Next-cycle implication, disabled during reset.
`define WVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wvm assertion failed");

`endif

/* src/wvm_pkg.sv */
// Shared types, field widths and action codes for the wavetable voice mixer.
package wvm_pkg;

   localparam int ACTION_W  = 3;
   localparam int INDEX_W   = 10;
   localparam int KEY_W     = 7;
   localparam int VEL_W     = 7;
   localparam int SAMPLE_W  = 16;
   localparam int STEP_W    = 26;
   localparam int DAC_W     = 12;
   localparam int KEY_COUNT = 128;

   localparam int FRAC_W    = 16;
   localparam int VOL_SHIFT = 4;
   localparam int MIX_SHIFT = 10;
   localparam int DAC_BIAS  = 2048;
   localparam int DAC_MAX   = 4095;

   localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_NOTE_ON   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_NOTE_OFF  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_LOAD_WAVE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LOAD_STEP = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TICK,
      ST_DRAIN,
      ST_FINISH,
      ST_OFF,
      ST_ON_STEP,
      ST_ON_SCAN,
      ST_STEP_RED,
      ST_STEP_WR
   } wvm_state_type;

   typedef struct packed {
      logic latch;
      logic rd_issue;
      logic tick_en;
      logic off_en;
      logic acc_clear;
      logic wave_wr;
      logic red_step;
      logic step_wr;
      logic on_write;
      logic out_load;
   } wvm_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                vel_zero;
      logic                cur_free;
      logic                off_match;
      logic                s1_last;
      logic                pipe_busy;
   } wvm_status_type;

   // Compare-subtract steps needed to bring a step value below the phase span.
   function automatic int red_step_count(input int table_size);
      int phase_w;
      int steps;
      phase_w = $clog2(table_size) + FRAC_W;
      steps   = STEP_W + 1 - phase_w;
      return (steps > 1) ? steps : 1;
   endfunction

endpackage

/* src/wvm_if.sv */
// Request and response channel interfaces of the wavetable voice mixer.
interface wvm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [wvm_pkg::ACTION_W-1:0]  action;
   logic        [wvm_pkg::INDEX_W-1:0]   table_index;
   logic        [wvm_pkg::KEY_W-1:0]     note_key;
   logic        [wvm_pkg::VEL_W-1:0]     velocity;
   logic signed [wvm_pkg::SAMPLE_W-1:0]  wave_sample;
   logic        [wvm_pkg::STEP_W-1:0]    step_value;

   modport source (output valid, action, table_index, note_key, velocity, wave_sample,
                   step_value, input ready);
   modport sink (input valid, action, table_index, note_key, velocity, wave_sample,
                 step_value, output ready);
endinterface

interface wvm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wvm_pkg::DAC_W-1:0]     dac_sample;

   modport source (output valid, dac_sample, input ready);
   modport sink (input valid, dac_sample, output ready);
endinterface

/* src/wvm_ram.sv */
// Generic single-write, single-read memory with registered read data.
module wvm_ram #(
   parameter int  WIDTH  = 16,
   parameter int  DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/wvm_datapath.sv */
// Datapath: word registers, voice/wave/step memories, mix pipeline, output register.
`include "wavetable_voice_mixer_defines.svh"

module wvm_datapath #(
   parameter int  TABLE_SIZE  = 1024,
   parameter int  VOICE_COUNT = 16,
   localparam int VI_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wvm_pkg::wvm_cmd_type                 cmd,
   input  logic        [VI_W-1:0]               voice_idx,
   output wvm_pkg::wvm_status_type              status,
   input  logic        [wvm_pkg::ACTION_W-1:0]  req_action,
   input  logic        [wvm_pkg::INDEX_W-1:0]   req_table_index,
   input  logic        [wvm_pkg::KEY_W-1:0]     req_note_key,
   input  logic        [wvm_pkg::VEL_W-1:0]     req_velocity,
   input  logic signed [wvm_pkg::SAMPLE_W-1:0]  req_wave_sample,
   input  logic        [wvm_pkg::STEP_W-1:0]    req_step_value,
   output logic        [wvm_pkg::DAC_W-1:0]     rsp_dac_sample
);

   localparam int WA_W      = $clog2(TABLE_SIZE);
   localparam int PHASE_W   = WA_W + wvm_pkg::FRAC_W;
   localparam int RED_STEPS = wvm_pkg::red_step_count(TABLE_SIZE);
   localparam int CMP_W     = PHASE_W + RED_STEPS;
   localparam int KEY_W     = wvm_pkg::KEY_W;
   localparam int VEL_W     = wvm_pkg::VEL_W;
   localparam int PH_LSB    = VEL_W;
   localparam int INC_LSB   = VEL_W + PHASE_W;
   localparam int KEY_LSB   = VEL_W + 2 * PHASE_W;
   localparam int VW        = KEY_LSB + KEY_W;
   localparam int PROD_W    = wvm_pkg::SAMPLE_W + VEL_W + 1;
   localparam int SCALED_W  = PROD_W - wvm_pkg::VOL_SHIFT;
   localparam int SUM_W     = SCALED_W + $clog2(VOICE_COUNT) + 1;
   localparam int BI_W      = SUM_W + 1;

   localparam logic [PHASE_W:0] SPAN_P =
      (PHASE_W + 1)'(longint'(TABLE_SIZE) << wvm_pkg::FRAC_W);
   localparam logic [CMP_W-1:0] DIV0 =
      CMP_W'(longint'(TABLE_SIZE) << (wvm_pkg::FRAC_W + RED_STEPS - 1));
   localparam logic [VI_W-1:0] LAST_VOICE = VI_W'(VOICE_COUNT - 1);

   // word registers
   logic        [wvm_pkg::ACTION_W-1:0] action_ff;
   logic        [wvm_pkg::INDEX_W-1:0]  index_ff;
   logic        [KEY_W-1:0]             key_ff;
   logic        [VEL_W-1:0]             vel_ff;
   logic signed [wvm_pkg::SAMPLE_W-1:0] sample_ff;
   logic        [CMP_W-1:0]             red_ff, red_in;
   logic        [CMP_W-1:0]             div_ff, div_in;

   logic [VOICE_COUNT-1:0] active_ff, active_in;

   // mix pipeline
   logic                     s1_v_ff;
   logic [VI_W-1:0]          s1_idx_ff;
   logic                     s2_v_ff;
   logic [VEL_W-1:0]         s2_vol_ff;
   logic                     s3_v_ff;
   logic signed [PROD_W-1:0] s3_prod_ff, prod_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic [wvm_pkg::DAC_W-1:0] dac_ff, dac_in;
   logic signed [BI_W-1:0]   biased;

   // memories
   logic [VW-1:0]                   voice_rd, voice_wr_data;
   logic [VI_W-1:0]                 voice_wr_addr;
   logic                            voice_wr_en;
   logic [wvm_pkg::SAMPLE_W-1:0]    wave_rd;
   logic [WA_W-1:0]                 wave_rd_addr;
   logic                            wave_wr_en;
   logic [PHASE_W-1:0]              step_rd;

   // stage 1 decode
   logic [KEY_W-1:0]   s1_key;
   logic [PHASE_W-1:0] s1_inc, s1_phase, new_phase;
   logic [VEL_W-1:0]   s1_vol;
   logic               s1_active;
   logic [PHASE_W:0]   phase_sum, phase_wrap;
   logic               tick_wr, off_hit;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff <= req_action;
         index_ff  <= req_table_index;
         key_ff    <= req_note_key;
         vel_ff    <= req_velocity;
         sample_ff <= req_wave_sample;
      end
      red_ff <= red_in;
      div_ff <= div_in;
   end

   // Reduce the step below the span, one restoring compare-subtract per cycle.
   always_comb begin
      red_in = red_ff;
      div_in = div_ff;
      if (cmd.latch) begin
         red_in = CMP_W'(req_step_value);
         div_in = DIV0;
      end else if (cmd.red_step) begin
         if (red_ff >= div_ff) begin
            red_in = red_ff - div_ff;
         end
         div_in = div_ff >> 1;
      end
   end

   assign s1_key    = voice_rd[KEY_LSB +: KEY_W];
   assign s1_inc    = voice_rd[INC_LSB +: PHASE_W];
   assign s1_phase  = voice_rd[PH_LSB +: PHASE_W];
   assign s1_vol    = voice_rd[VEL_W-1:0];
   assign s1_active = active_ff[s1_idx_ff];

   assign phase_sum  = {1'b0, s1_phase} + {1'b0, s1_inc};
   assign phase_wrap = (phase_sum >= SPAN_P) ? phase_sum - SPAN_P : phase_sum;
   assign new_phase  = phase_wrap[PHASE_W-1:0];

   assign tick_wr = cmd.tick_en && s1_v_ff && s1_active;
   assign off_hit = cmd.off_en && s1_v_ff && s1_active && (s1_key == key_ff);

   always_comb begin
      active_in = active_ff;
      if (cmd.on_write) begin
         active_in[voice_idx] = 1'b1;
      end
      if (off_hit) begin
         active_in[s1_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         s1_v_ff   <= cmd.rd_issue;
         s2_v_ff   <= tick_wr;
         s3_v_ff   <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= voice_idx;
      s2_vol_ff  <= s1_vol;
      s3_prod_ff <= prod_in;
      acc_ff     <= acc_in;
      if (cmd.out_load) begin
         dac_ff <= dac_in;
      end
   end

   // Note-on writes a fresh voice; a tick writes back the advanced phase.
   always_comb begin
      voice_wr_en = cmd.on_write || tick_wr;
      if (cmd.on_write) begin
         voice_wr_addr = voice_idx;
         voice_wr_data = {key_ff, step_rd, PHASE_W'(0), vel_ff};
      end else begin
         voice_wr_addr = s1_idx_ff;
         voice_wr_data = {s1_key, s1_inc, new_phase, s1_vol};
      end
   end

   assign wave_rd_addr = new_phase[PHASE_W-1:wvm_pkg::FRAC_W];
   assign wave_wr_en   = cmd.wave_wr && (32'(index_ff) < 32'(TABLE_SIZE));

   assign prod_in = $signed(wave_rd) * $signed({1'b0, s2_vol_ff});

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (s3_v_ff) begin
         acc_in = acc_ff + SUM_W'(s3_prod_ff >>> wvm_pkg::VOL_SHIFT);
      end
   end

   always_comb begin
      biased = BI_W'(acc_ff >>> wvm_pkg::MIX_SHIFT) + BI_W'(wvm_pkg::DAC_BIAS);
      if (biased < 0) begin
         dac_in = '0;
      end else if (biased > BI_W'(wvm_pkg::DAC_MAX)) begin
         dac_in = wvm_pkg::DAC_W'(wvm_pkg::DAC_MAX);
      end else begin
         dac_in = biased[wvm_pkg::DAC_W-1:0];
      end
   end

   wvm_ram #(.WIDTH(VW), .DEPTH(VOICE_COUNT)) u_voice_ram (
      .clock   (clock),
      .wr_en   (voice_wr_en),
      .wr_addr (voice_wr_addr),
      .wr_data (voice_wr_data),
      .rd_addr (voice_idx),
      .rd_data (voice_rd)
   );

   wvm_ram #(.WIDTH(wvm_pkg::SAMPLE_W), .DEPTH(TABLE_SIZE)) u_wave_ram (
      .clock   (clock),
      .wr_en   (wave_wr_en),
      .wr_addr (WA_W'(index_ff)),
      .wr_data (sample_ff),
      .rd_addr (wave_rd_addr),
      .rd_data (wave_rd)
   );

   wvm_ram #(.WIDTH(PHASE_W), .DEPTH(wvm_pkg::KEY_COUNT)) u_step_ram (
      .clock   (clock),
      .wr_en   (cmd.step_wr),
      .wr_addr (index_ff[KEY_W-1:0]),
      .wr_data (red_ff[PHASE_W-1:0]),
      .rd_addr (key_ff),
      .rd_data (step_rd)
   );

   assign status.action    = action_ff;
   assign status.vel_zero  = (vel_ff == '0);
   assign status.cur_free  = !active_ff[voice_idx];
   assign status.off_match = off_hit;
   assign status.s1_last   = s1_v_ff && (s1_idx_ff == LAST_VOICE);
   assign status.pipe_busy = s1_v_ff || s2_v_ff || s3_v_ff;

   assign rsp_dac_sample = dac_ff;

   `WVM_ASSERT_IMPLY(a_phase_in_span, clock, reset, tick_wr, phase_wrap < SPAN_P)
   `WVM_ASSERT_IMPLY(a_on_free_voice, clock, reset, cmd.on_write, !active_ff[voice_idx])
   `WVM_ASSERT_IMPLY(a_pipe_empty_at_start, clock, reset, cmd.acc_clear, !s1_v_ff && !s2_v_ff && !s3_v_ff)

endmodule

/* src/wvm_ctrl.sv */
// Controller: sequences each word through dispatch, voice scans, reduction and output.
`include "wavetable_voice_mixer_defines.svh"

module wvm_ctrl #(
   parameter int  TABLE_SIZE  = 1024,
   parameter int  VOICE_COUNT = 16,
   localparam int VI_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1,
   localparam int RED_STEPS = wvm_pkg::red_step_count(TABLE_SIZE),
   localparam int RC_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output wvm_pkg::wvm_cmd_type    cmd,
   output logic [VI_W-1:0]         voice_idx,
   input  wvm_pkg::wvm_status_type status
);

   localparam logic [VI_W-1:0] LAST_VOICE = VI_W'(VOICE_COUNT - 1);
   localparam logic [RC_W-1:0] LAST_RED   = RC_W'(RED_STEPS - 1);

   wvm_pkg::wvm_state_type state_ff, state_in;
   logic [VI_W-1:0]        cnt_ff, cnt_in;
   logic [RC_W-1:0]        red_cnt_ff, red_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wvm_pkg::ST_IDLE: begin
            if (req_valid) state_in = wvm_pkg::ST_DISPATCH;
         end
         wvm_pkg::ST_DISPATCH: begin
            unique case (status.action)
               wvm_pkg::ACT_TICK:      state_in = wvm_pkg::ST_TICK;
               wvm_pkg::ACT_NOTE_ON:   state_in = status.vel_zero ? wvm_pkg::ST_OFF
                                                                  : wvm_pkg::ST_ON_STEP;
               wvm_pkg::ACT_NOTE_OFF:  state_in = wvm_pkg::ST_OFF;
               wvm_pkg::ACT_LOAD_STEP: state_in = wvm_pkg::ST_STEP_RED;
               default:                state_in = wvm_pkg::ST_IDLE;
            endcase
         end
         wvm_pkg::ST_TICK: begin
            if (cnt_ff == LAST_VOICE) state_in = wvm_pkg::ST_DRAIN;
         end
         wvm_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) state_in = wvm_pkg::ST_FINISH;
         end
         wvm_pkg::ST_FINISH: begin
            if (out_free) state_in = wvm_pkg::ST_IDLE;
         end
         wvm_pkg::ST_OFF: begin
            if (status.off_match || status.s1_last) state_in = wvm_pkg::ST_IDLE;
         end
         wvm_pkg::ST_ON_STEP: begin
            state_in = wvm_pkg::ST_ON_SCAN;
         end
         wvm_pkg::ST_ON_SCAN: begin
            // take the first free voice, drop the note when none is left
            if (status.cur_free || cnt_ff == LAST_VOICE) state_in = wvm_pkg::ST_IDLE;
         end
         wvm_pkg::ST_STEP_RED: begin
            if (red_cnt_ff == LAST_RED) state_in = wvm_pkg::ST_STEP_WR;
         end
         wvm_pkg::ST_STEP_WR: begin
            state_in = wvm_pkg::ST_IDLE;
         end
         default: state_in = wvm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         wvm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         wvm_pkg::ST_DISPATCH: begin
            cmd.acc_clear = (status.action == wvm_pkg::ACT_TICK);
            cmd.wave_wr   = (status.action == wvm_pkg::ACT_LOAD_WAVE);
         end
         wvm_pkg::ST_TICK: begin
            cmd.rd_issue = 1'b1;
            cmd.tick_en  = 1'b1;
         end
         wvm_pkg::ST_DRAIN: begin
            cmd.tick_en = 1'b1;
         end
         wvm_pkg::ST_FINISH: begin
            cmd.out_load = out_free;
         end
         wvm_pkg::ST_OFF: begin
            cmd.rd_issue = 1'b1;
            cmd.off_en   = 1'b1;
         end
         wvm_pkg::ST_ON_STEP: begin
         end
         wvm_pkg::ST_ON_SCAN: begin
            cmd.on_write = status.cur_free;
         end
         wvm_pkg::ST_STEP_RED: begin
            cmd.red_step = 1'b1;
         end
         wvm_pkg::ST_STEP_WR: begin
            cmd.step_wr = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      red_cnt_in   = red_cnt_ff;
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
      unique case (state_ff)
         wvm_pkg::ST_DISPATCH: begin
            cnt_in     = '0;
            red_cnt_in = '0;
         end
         wvm_pkg::ST_TICK: begin
            cnt_in = cnt_ff + 1'b1;
         end
         wvm_pkg::ST_OFF, wvm_pkg::ST_ON_SCAN: begin
            // hold on the last voice
            if (cnt_ff != LAST_VOICE) cnt_in = cnt_ff + 1'b1;
         end
         wvm_pkg::ST_STEP_RED: begin
            red_cnt_in = red_cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wvm_pkg::ST_IDLE;
         cnt_ff       <= '0;
         red_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         red_cnt_ff   <= red_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign voice_idx = cnt_ff;
   assign rsp_valid = rsp_valid_ff;

   `WVM_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && req_ready, state_ff == wvm_pkg::ST_DISPATCH)
   `WVM_ASSERT_NEXT(a_load_shows_valid, clock, reset, cmd.out_load, rsp_valid_ff)

endmodule

/* src/wavetable_voice_mixer.sv */
// Tick: one voice per cycle through the voice memory and a three-stage phase/wave/multiply
// pipeline; the sum is loaded into the output register once the pipeline drains.
// Note on and note off: one-voice-per-cycle scan. Next word taken when idle.
// Step load: reduction steps, then a step memory write; wave load: a single write.
// Reset clears voice activity, controller and output valid; wave and step memories
// are not cleared and hold unknown data until loaded.
module wavetable_voice_mixer #(
   parameter int TABLE_SIZE  = 1024,
   parameter int VOICE_COUNT = 16
) (
   input logic        clock,
   input logic        reset,
   wvm_req_if.sink    req_bus,
   wvm_rsp_if.source  rsp_bus
);

   localparam int VI_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

   wvm_pkg::wvm_cmd_type    cmd;
   wvm_pkg::wvm_status_type status;
   logic [VI_W-1:0]         voice_idx;
   logic                    req_ready;
   logic                    rsp_valid;

   wvm_ctrl #(.TABLE_SIZE(TABLE_SIZE), .VOICE_COUNT(VOICE_COUNT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .voice_idx (voice_idx),
      .status    (status)
   );

   wvm_datapath #(.TABLE_SIZE(TABLE_SIZE), .VOICE_COUNT(VOICE_COUNT)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .voice_idx       (voice_idx),
      .status          (status),
      .req_action      (req_bus.action),
      .req_table_index (req_bus.table_index),
      .req_note_key    (req_bus.note_key),
      .req_velocity    (req_bus.velocity),
      .req_wave_sample (req_bus.wave_sample),
      .req_step_value  (req_bus.step_value),
      .rsp_dac_sample  (rsp_bus.dac_sample)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the wavetable voice mixer: predicted mix samples against the DUT.
`timescale 1ns / 100ps

module tb_top;
   import wvm_pkg::*;

   localparam int TABLE_SIZE      = 1024;
   localparam int VOICE_COUNT     = 16;
   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 9;
   localparam int RANDOM_WORDS    = 760;
   localparam int BURST_WORDS     = 60;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam int WATCHDOG_LIMIT  = 8000;
   localparam int DRAIN_CYCLES    = VOICE_COUNT + 16;
   localparam int PRINT_CAP       = 40;
   localparam int KEY_SPACING     = 17;
   localparam int unsigned PHASE_SPAN = TABLE_SIZE << FRAC_W;
   localparam logic [STEP_W-1:0] STEP_MAX = '1;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

   typedef struct {
      logic [ACTION_W-1:0]        action;
      logic [INDEX_W-1:0]         table_index;
      logic [KEY_W-1:0]           note_key;
      logic [VEL_W-1:0]           velocity;
      logic signed [SAMPLE_W-1:0] wave_sample;
      logic [STEP_W-1:0]          step_value;
   } mixer_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wvm_req_if req_bus ();
   wvm_rsp_if rsp_bus ();

   wavetable_voice_mixer #(
      .TABLE_SIZE  (TABLE_SIZE),
      .VOICE_COUNT (VOICE_COUNT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // mixer state as the testbench predicts it
   bit                         voice_on    [VOICE_COUNT];
   logic [KEY_W-1:0]           voice_note  [VOICE_COUNT];
   logic [STEP_W-1:0]          voice_step  [VOICE_COUNT];
   int unsigned                voice_phase [VOICE_COUNT];
   logic [VEL_W-1:0]           voice_level [VOICE_COUNT];
   logic signed [SAMPLE_W-1:0] wave_mem    [TABLE_SIZE];
   bit                         wave_loaded [TABLE_SIZE];
   logic [STEP_W-1:0]          step_mem    [KEY_COUNT];
   bit                         step_loaded [KEY_COUNT];

   logic [DAC_W-1:0] expected_dac [$];
   int  error_count   = 0;
   int  hold_off_left = 0;
   bit  burst_mode    = 1'b0;
   int  idle_cycles   = 0;

   always #(CLOCK_HALF) clock = ~clock;

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic int unsigned next_phase(input int v);
      int unsigned s;
      s = voice_phase[v] + voice_step[v];
      return s % PHASE_SPAN;
   endfunction

   function automatic void release_note(input logic [KEY_W-1:0] key);
      bit done;
      done = 1'b0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
         if (!done && voice_on[v] && voice_note[v] == key) begin
            voice_on[v] = 1'b0;
            done = 1'b1;
         end
      end
   endfunction

   // Advance the predicted state by one accepted word; flag a tick's mix sample.
   function automatic void mix_word(input mixer_word_t w, output bit gives_dac,
                                    output logic [DAC_W-1:0] dac);
      int sum;
      int smp;
      int lvl;
      int unsigned ph;
      bit done;
      gives_dac = 1'b0;
      dac = '0;
      case (w.action)
         ACT_TICK: begin
            sum = 0;
            for (int v = 0; v < VOICE_COUNT; v++) begin
               if (voice_on[v]) begin
                  ph = next_phase(v);
                  voice_phase[v] = ph;
                  smp = wave_mem[ph >> FRAC_W];
                  lvl = voice_level[v];
                  sum += (smp * lvl) >>> VOL_SHIFT;
               end
            end
            sum = (sum >>> MIX_SHIFT) + DAC_BIAS;
            if (sum > DAC_MAX) sum = DAC_MAX;
            else if (sum < 0) sum = 0;
            gives_dac = 1'b1;
            dac = sum[DAC_W-1:0];
         end
         ACT_NOTE_ON: begin
            if (w.velocity == 0) begin
               release_note(w.note_key);
            end else begin
               // take the lowest free voice, drop the note if none
               done = 1'b0;
               for (int v = 0; v < VOICE_COUNT; v++) begin
                  if (!done && !voice_on[v]) begin
                     voice_note[v]  = w.note_key;
                     voice_step[v]  = step_mem[w.note_key];
                     voice_phase[v] = 0;
                     voice_level[v] = w.velocity;
                     voice_on[v]    = 1'b1;
                     done = 1'b1;
                  end
               end
            end
         end
         ACT_NOTE_OFF: release_note(w.note_key);
         ACT_LOAD_WAVE: begin
            if (w.table_index < TABLE_SIZE) begin
               wave_mem[w.table_index]    = w.wave_sample;
               wave_loaded[w.table_index] = 1'b1;
            end
         end
         ACT_LOAD_STEP: begin
            step_mem[w.table_index[KEY_W-1:0]]    = w.step_value;
            step_loaded[w.table_index[KEY_W-1:0]] = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic mixer_word_t junk_word(input logic [ACTION_W-1:0] act);
      mixer_word_t w;
      w.action      = act;
      w.table_index = $urandom_range(0, (1 << INDEX_W) - 1);
      w.note_key    = $urandom_range(0, KEY_COUNT - 1);
      w.velocity    = $urandom_range(0, (1 << VEL_W) - 1);
      w.wave_sample = $urandom;
      w.step_value  = $urandom;
      return w;
   endfunction

   function automatic mixer_word_t random_word();
      mixer_word_t w;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 38) w = junk_word(ACT_TICK);
      else if (pick < 63) w = junk_word(ACT_NOTE_ON);
      else if (pick < 78) w = junk_word(ACT_NOTE_OFF);
      else if (pick < 88) w = junk_word(ACT_LOAD_WAVE);
      else if (pick < 96) w = junk_word(ACT_LOAD_STEP);
      else w = junk_word($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      // keep most notes on a few keys so note off finds its voice
      if ((w.action == ACT_NOTE_ON || w.action == ACT_NOTE_OFF) && $urandom_range(0, 3) != 0)
         w.note_key = $urandom_range(0, 7) * KEY_SPACING;
      if (w.action == ACT_NOTE_ON)
         w.velocity = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (1 << VEL_W) - 1);
      if (w.action == ACT_LOAD_STEP && $urandom_range(0, 1) != 0)
         w.step_value = $urandom_range(0, 1 << 20);
      if (w.action == ACT_LOAD_WAVE)
         w.table_index = $urandom_range(0, TABLE_SIZE - 1);
      return w;
   endfunction

   task automatic send_word(input mixer_word_t w);
      int gap;
      bit gives_dac;
      logic [DAC_W-1:0] dac;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= w.action;
      req_bus.table_index <= w.table_index;
      req_bus.note_key    <= w.note_key;
      req_bus.velocity    <= w.velocity;
      req_bus.wave_sample <= w.wave_sample;
      req_bus.step_value  <= w.step_value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      mix_word(w, gives_dac, dac);
      if (gives_dac) expected_dac.push_back(dac);
   endtask

   // Load any table entry the word is about to read, then send it.
   task automatic play_word(input mixer_word_t w);
      mixer_word_t fill;
      int unsigned idx;
      bit has_free;
      if (w.action == ACT_TICK) begin
         for (int v = 0; v < VOICE_COUNT; v++) begin
            if (voice_on[v]) begin
               idx = next_phase(v) >> FRAC_W;
               if (!wave_loaded[idx]) begin
                  fill = junk_word(ACT_LOAD_WAVE);
                  fill.table_index = idx;
                  send_word(fill);
               end
            end
         end
      end else if (w.action == ACT_NOTE_ON && w.velocity != 0 && !step_loaded[w.note_key]) begin
         has_free = 1'b0;
         for (int v = 0; v < VOICE_COUNT; v++)
            if (!voice_on[v]) has_free = 1'b1;
         if (has_free) begin
            fill = junk_word(ACT_LOAD_STEP);
            fill.table_index[KEY_W-1:0] = w.note_key;
            send_word(fill);
         end
      end
      send_word(w);
   endtask

   task automatic test_empty_mix_and_unused();
      play_word(junk_word(ACT_TICK));
      play_word(junk_word(ACT_UNUSED_HI));
   endtask

   task automatic test_table_extremes();
      mixer_word_t w;
      w = junk_word(ACT_LOAD_STEP);
      w.table_index = 10'h380;
      w.step_value  = '0;
      play_word(w);
      w = junk_word(ACT_LOAD_STEP);
      w.table_index = '1;
      w.step_value  = STEP_MAX;
      play_word(w);
      w = junk_word(ACT_LOAD_WAVE);
      w.table_index = 0;
      w.wave_sample = 16'sh7FFF;
      play_word(w);
      w = junk_word(ACT_LOAD_WAVE);
      w.table_index = TABLE_SIZE - 1;
      w.wave_sample = 16'sh8000;
      play_word(w);
   endtask

   task automatic test_voice_overflow_and_clamp();
      mixer_word_t w;
      // one note more than there are voices: the last is dropped
      for (int n = 0; n <= VOICE_COUNT; n++) begin
         w = junk_word(ACT_NOTE_ON);
         w.note_key = 0;
         w.velocity = '1;
         play_word(w);
      end
      play_word(junk_word(ACT_TICK));
      w = junk_word(ACT_LOAD_WAVE);
      w.table_index = 0;
      w.wave_sample = 16'sh8000;
      play_word(w);
      play_word(junk_word(ACT_TICK));
      w = junk_word(ACT_NOTE_OFF);
      w.note_key = 0;
      play_word(w);
      w = junk_word(ACT_NOTE_ON);
      w.note_key = '1;
      w.velocity = 1;
      play_word(w);
      play_word(junk_word(ACT_TICK));
      w = junk_word(ACT_NOTE_ON);
      w.note_key = '1;
      w.velocity = 0;
      play_word(w);
      w = junk_word(ACT_NOTE_OFF);
      w.note_key = 5;
      play_word(w);
      play_word(junk_word(ACT_TICK));
   endtask

   task automatic test_back_to_back();
      burst_mode = 1'b1;
      repeat (BURST_WORDS) play_word(random_word());
      burst_mode = 1'b0;
   endtask

   task automatic test_output_backpressure();
      hold_off_left = HOLD_OFF_CYCLES;
      burst_mode = 1'b1;
      repeat (12) play_word(junk_word(ACT_TICK));
      burst_mode = 1'b0;
   endtask

   task automatic test_random_mix();
      mixer_word_t w;
      int n;
      n = 0;
      while (n < RANDOM_WORDS) begin
         w = random_word();
         play_word(w);
         if (w.action < ACT_UNUSED_LO) n++;
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin : rsp_ready_drive
      int run_left;
      bit level;
      run_left = 0;
      level = 1'b1;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            level = 1'b0;
            run_left = 0;
         end else if (burst_mode) begin
            level = 1'b1;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            level = ~level;
            run_left = level ? $urandom_range(0, 20) : pick_gap();
         end
         rsp_bus.ready <= level;
      end
   end

   always @(posedge clock) begin
      logic [DAC_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_dac.size() == 0) begin
            report_mismatch($sformatf("dac_sample %0d with no tick pending", rsp_bus.dac_sample));
         end else begin
            want = expected_dac.pop_front();
            if (rsp_bus.dac_sample !== want)
               report_mismatch($sformatf("dac_sample got %0d want %0d", rsp_bus.dac_sample, want));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.action      <= ACT_TICK;
      req_bus.table_index <= '0;
      req_bus.note_key    <= '0;
      req_bus.velocity    <= '0;
      req_bus.wave_sample <= '0;
      req_bus.step_value  <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
         voice_on[v]    = 1'b0;
         voice_note[v]  = '0;
         voice_step[v]  = '0;
         voice_phase[v] = 0;
         voice_level[v] = '0;
      end
      for (int i = 0; i < TABLE_SIZE; i++) begin
         wave_mem[i]    = '0;
         wave_loaded[i] = 1'b0;
      end
      for (int k = 0; k < KEY_COUNT; k++) begin
         step_mem[k]    = '0;
         step_loaded[k] = 1'b0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_mix_and_unused();
      test_table_extremes();
      test_voice_overflow_and_clamp();
      test_back_to_back();
      test_output_backpressure();
      test_random_mix();

      req_bus.valid <= 1'b0;
      while (expected_dac.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/wvm_pkg.sv
src/wvm_if.sv
src/wvm_ram.sv
src/wvm_datapath.sv
src/wvm_ctrl.sv
src/wavetable_voice_mixer.sv
tb/tb_top.sv
